// ----- hw/rtl/cp_pkg.sv -----
// ----------------------------------------------------------------------------
// cp_pkg: shared types and constants for the rectangular-to-polar converter
// Holds the transfer payload types, the rotation datapath record that moves
// down the cell chain, and the arctangent table used by the rotation cells.
// ----------------------------------------------------------------------------
package cp_pkg;

    // Default configuration of the converter.
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // Width of each payload field.
    localparam int FIELD_W = 16;

    // Rotation datapath: inputs are scaled so that their binary point sits
    // at SCALE_POINT minus the data width, in a wide signed word.
    localparam int SCALE_POINT = 60;
    localparam int CORD_W      = 64;

    // Angle accumulator: one full turn is 2^ACC_W.
    localparam int ACC_W    = 32;
    localparam int ATAN_LEN = 32;

    localparam logic [ACC_W-1:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ANGLE_ROUND = 32'h0000_8000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [ACC_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Input transfer: one rectangular vector.
    typedef struct packed {
        logic signed [FIELD_W-1:0] x_component;
        logic signed [FIELD_W-1:0] y_component;
    } vec_t;

    // Output transfer: magnitude and binary angle.
    typedef struct packed {
        logic [FIELD_W-1:0] magnitude;
        logic [FIELD_W-1:0] angle;
    } polar_t;

    // Rotation state carried from cell to cell.
    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic [ACC_W-1:0]         acc;
        logic                     zero;
    } cord_t;

endpackage

// ----- hw/rtl/cp_front.sv -----
// ----------------------------------------------------------------------------
// cp_front: input conditioning for the converter
// Two pipeline stages: the first squares both components and folds the
// vector into the right half plane; the second adds the squares.
// ----------------------------------------------------------------------------
module cp_front #(
    parameter int DATA_WIDTH = cp_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cp_pkg::vec_t              vec,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cp_pkg::cord_t             cord,
    output logic [2*DATA_WIDTH-1:0]   sum
);

    localparam int SQ_W  = 2 * DATA_WIDTH;
    localparam int GUARD = cp_pkg::SCALE_POINT - DATA_WIDTH;

    logic signed [DATA_WIDTH-1:0]     x_in;
    logic signed [DATA_WIDTH-1:0]     y_in;
    logic signed [SQ_W-1:0]           sq_x_prod;
    logic signed [SQ_W-1:0]           sq_y_prod;
    logic signed [cp_pkg::CORD_W-1:0] x_scaled;
    logic signed [cp_pkg::CORD_W-1:0] y_scaled;
    cp_pkg::cord_t                    cord_init;

    logic                a_valid_reg, a_valid_next;
    logic [SQ_W-1:0]     sq_x_reg, sq_x_next;
    logic [SQ_W-1:0]     sq_y_reg, sq_y_next;
    cp_pkg::cord_t       a_cord_reg, a_cord_next;
    logic                b_valid_reg, b_valid_next;
    logic [SQ_W-1:0]     sum_reg, sum_next;
    cp_pkg::cord_t       b_cord_reg, b_cord_next;
    logic                a_ready;
    logic                b_ready;

    // Only the low DATA_WIDTH bits of each field carry the component.
    assign x_in = DATA_WIDTH'($unsigned(vec.x_component));
    assign y_in = DATA_WIDTH'($unsigned(vec.y_component));

    // Squares of the components; both are non-negative and fit in SQ_W bits.
    assign sq_x_prod = x_in * x_in;
    assign sq_y_prod = y_in * y_in;

    // Scale up, and rotate by a half turn when x is negative.
    assign x_scaled = cp_pkg::CORD_W'(x_in) <<< GUARD;
    assign y_scaled = cp_pkg::CORD_W'(y_in) <<< GUARD;

    always_comb
    begin
        cord_init.zero = (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            cord_init.cx  = -x_scaled;
            cord_init.cy  = -y_scaled;
            cord_init.acc = cp_pkg::HALF_TURN;
        end
        else
        begin
            cord_init.cx  = x_scaled;
            cord_init.cy  = y_scaled;
            cord_init.acc = '0;
        end
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Next values of both stages.
    always_comb
    begin
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        sq_x_next    = sq_x_reg;
        sq_y_next    = sq_y_reg;
        a_cord_next  = a_cord_reg;
        if (a_ready && in_valid)
        begin
            sq_x_next   = $unsigned(sq_x_prod);
            sq_y_next   = $unsigned(sq_y_prod);
            a_cord_next = cord_init;
        end

        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        sum_next     = sum_reg;
        b_cord_next  = b_cord_reg;
        if (b_ready && a_valid_reg)
        begin
            sum_next    = sq_x_reg + sq_y_reg;
            b_cord_next = a_cord_reg;
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        sq_x_reg   <= sq_x_next;
        sq_y_reg   <= sq_y_next;
        a_cord_reg <= a_cord_next;
        sum_reg    <= sum_next;
        b_cord_reg <= b_cord_next;
    end

    assign out_valid = b_valid_reg;
    assign cord      = b_cord_reg;
    assign sum       = sum_reg;

endmodule

// ----- hw/rtl/cp_cell.sv -----
// ----------------------------------------------------------------------------
// cp_cell: one cell of the converter chain
// Performs one vectoring rotation step and one digit of the integer square
// root, then hands both to the next cell. Cells past the last rotation or
// the last root digit pass that part through unchanged.
// ----------------------------------------------------------------------------
module cp_cell #(
    parameter int DATA_WIDTH = cp_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = cp_pkg::ITERATIONS_DEF,
    parameter int STAGE      = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cp_pkg::cord_t             cord_in,
    input  logic [2*DATA_WIDTH-1:0]   s_in,
    input  logic [2*DATA_WIDTH-1:0]   r_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cp_pkg::cord_t             cord_out,
    output logic [2*DATA_WIDTH-1:0]   s_out,
    output logic [2*DATA_WIDTH-1:0]   r_out
);

    localparam int SQ_W       = 2 * DATA_WIDTH;
    localparam int ROOT_SHIFT = (STAGE < DATA_WIDTH) ? 2 * (DATA_WIDTH - 1 - STAGE) : 0;
    localparam logic [SQ_W-1:0] ROOT_BIT = SQ_W'(1) << ROOT_SHIFT;

    cp_pkg::cord_t     cord_step;
    logic [SQ_W-1:0]   s_step;
    logic [SQ_W-1:0]   r_step;

    logic              valid_reg, valid_next;
    cp_pkg::cord_t     cord_reg, cord_next;
    logic [SQ_W-1:0]   s_reg, s_next;
    logic [SQ_W-1:0]   r_reg, r_next;

    // Rotation step: drive y toward zero, accumulating the angle turned.
    generate
        if (STAGE < ITERATIONS)
        begin : g_rot
            logic signed [cp_pkg::CORD_W-1:0] dx;
            logic signed [cp_pkg::CORD_W-1:0] dy;

            assign dx = $signed(cord_in.cy) >>> STAGE;
            assign dy = $signed(cord_in.cx) >>> STAGE;

            always_comb
            begin
                cord_step.zero = cord_in.zero;
                if (!cord_in.cy[cp_pkg::CORD_W-1])
                begin
                    cord_step.cx  = cord_in.cx + dx;
                    cord_step.cy  = cord_in.cy - dy;
                    cord_step.acc = cord_in.acc + cp_pkg::ATAN_TAB[STAGE];
                end
                else
                begin
                    cord_step.cx  = cord_in.cx - dx;
                    cord_step.cy  = cord_in.cy + dy;
                    cord_step.acc = cord_in.acc - cp_pkg::ATAN_TAB[STAGE];
                end
            end
        end
        else
        begin : g_rot_pass
            assign cord_step = cord_in;
        end
    endgenerate

    // Root digit: try to subtract the current trial value from the remainder.
    generate
        if (STAGE < DATA_WIDTH)
        begin : g_root
            logic [SQ_W:0] trial;
            logic          take;

            assign trial = {1'b0, r_in} + {1'b0, ROOT_BIT};
            assign take  = {1'b0, s_in} >= trial;

            always_comb
            begin
                if (take)
                begin
                    s_step = s_in - trial[SQ_W-1:0];
                    r_step = (r_in >> 1) + ROOT_BIT;
                end
                else
                begin
                    s_step = s_in;
                    r_step = r_in >> 1;
                end
            end
        end
        else
        begin : g_root_pass
            assign s_step = s_in;
            assign r_step = r_in;
        end
    endgenerate

    // The cell loads when it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        cord_next  = cord_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        if (in_ready && in_valid)
        begin
            cord_next = cord_step;
            s_next    = s_step;
            r_next    = r_step;
        end
    end

    // Cell occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Cell payload.
    always_ff @(posedge clk)
    begin
        cord_reg <= cord_next;
        s_reg    <= s_next;
        r_reg    <= r_next;
    end

    assign out_valid = valid_reg;
    assign cord_out  = cord_reg;
    assign s_out     = s_reg;
    assign r_out     = r_reg;

endmodule

// ----- hw/rtl/cp_back.sv -----
// ----------------------------------------------------------------------------
// cp_back: result rounding and output register
// Rounds the square root to nearest and the angle accumulator to 16 bits,
// and holds the finished result until the output transfer completes.
// ----------------------------------------------------------------------------
module cp_back #(
    parameter int DATA_WIDTH = cp_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cp_pkg::cord_t             cord,
    input  logic [2*DATA_WIDTH-1:0]   s,
    input  logic [2*DATA_WIDTH-1:0]   r,
    output logic                      polar_valid,
    input  logic                      polar_stall,
    output cp_pkg::polar_t            polar
);

    logic [DATA_WIDTH:0]        mag_round;
    logic [cp_pkg::ACC_W-1:0]   acc_round;
    cp_pkg::polar_t             result;

    logic                       valid_reg, valid_next;
    cp_pkg::polar_t             polar_reg, polar_next;

    // Round up when the remainder exceeds the root.
    assign mag_round = (DATA_WIDTH + 1)'(r) + (DATA_WIDTH + 1)'(s > r);
    assign acc_round = cord.acc + cp_pkg::ANGLE_ROUND;

    always_comb
    begin
        result.magnitude = cp_pkg::FIELD_W'(mag_round);
        if (cord.zero)
        begin
            result.angle = '0;
        end
        else
        begin
            result.angle = acc_round[cp_pkg::ACC_W-1 -: cp_pkg::FIELD_W];
        end
    end

    // The output register frees as soon as its result is taken.
    assign in_ready = !valid_reg || !polar_stall;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        polar_next = (in_ready && in_valid) ? result : polar_reg;
    end

    // Output occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        polar_reg <= polar_next;
    end

    assign polar_valid = valid_reg;
    assign polar       = polar_reg;

endmodule

// ----- hw/rtl/cartesian_to_polar.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_polar: rectangular-to-polar vector converter
// Converts a signed vector to its rounded Euclidean length and its
// four-quadrant direction as a 16-bit binary angle.
//
//   Channel   Signals                     Payload
//   input     vec_valid / vec_stall       vec: x_component, y_component
//   output    polar_valid / polar_stall   polar: magnitude, angle
//
// One vector is taken every cycle while vec_stall is low. CHAIN_LEN cells, the
// larger of ITERATIONS and DATA_WIDTH, sit between two front stages and the
// output register. Reset empties every stage; no result is pending after reset.
// An output stall fills the chain bubble by bubble; vec_stall rises only when
// every stage holds an item.
// ----------------------------------------------------------------------------
module cartesian_to_polar #(
    parameter int DATA_WIDTH = cp_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = cp_pkg::ITERATIONS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vec_valid,
    output logic            vec_stall,
    input  cp_pkg::vec_t    vec,
    output logic            polar_valid,
    input  logic            polar_stall,
    output cp_pkg::polar_t  polar
);

    localparam int SQ_W      = 2 * DATA_WIDTH;
    localparam int CHAIN_LEN = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;

    logic            front_ready;
    logic            link_valid [CHAIN_LEN+1];
    logic            link_ready [CHAIN_LEN+1];
    cp_pkg::cord_t   link_cord  [CHAIN_LEN+1];
    logic [SQ_W-1:0] link_s     [CHAIN_LEN+1];
    logic [SQ_W-1:0] link_r     [CHAIN_LEN+1];

    // Squares, sum and half-plane folding.
    cp_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_valid),
        .in_ready  (front_ready),
        .vec       (vec),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .cord      (link_cord[0]),
        .sum       (link_s[0])
    );

    assign vec_stall = !front_ready;
    assign link_r[0] = '0;

    // Chain of rotation and root cells.
    generate
        for (genvar k = 0; k < CHAIN_LEN; k++)
        begin : g_chain
            cp_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .ITERATIONS (ITERATIONS),
                .STAGE      (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (link_valid[k]),
                .in_ready  (link_ready[k]),
                .cord_in   (link_cord[k]),
                .s_in      (link_s[k]),
                .r_in      (link_r[k]),
                .out_valid (link_valid[k+1]),
                .out_ready (link_ready[k+1]),
                .cord_out  (link_cord[k+1]),
                .s_out     (link_s[k+1]),
                .r_out     (link_r[k+1])
            );
        end
    endgenerate

    // Rounding and output register.
    cp_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (link_valid[CHAIN_LEN]),
        .in_ready    (link_ready[CHAIN_LEN]),
        .cord        (link_cord[CHAIN_LEN]),
        .s           (link_s[CHAIN_LEN]),
        .r           (link_r[CHAIN_LEN]),
        .polar_valid (polar_valid),
        .polar_stall (polar_stall),
        .polar       (polar)
    );

    // A free output lets the whole chain advance, so input cannot stall.
    a_free_output_no_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !polar_stall |-> !vec_stall
    ) else $error("input stalled while the output was free");

    // Input back-pressure needs a result waiting at the output.
    a_stall_needs_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        vec_stall |-> polar_valid
    ) else $error("input stalled with an empty output register");

    // Only the zero vector has zero length, and its angle is zero.
    a_zero_length_angle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (DATA_WIDTH <= cp_pkg::FIELD_W) && polar_valid && (polar.magnitude == '0)
            |-> (polar.angle == '0)
    ) else $error("zero magnitude with a nonzero angle");

endmodule

// ----- dv/tb_cartesian_to_polar.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar: self-checking bench for the vector converter
// Streams directed and random vectors into the converter under several
// idle and stall patterns, predicts each magnitude and CORDIC angle in the
// bench, and compares every output transfer in order against the prediction.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar;

    localparam int VEC_W      = 16;
    localparam int ROT_STAGES = 16;
    localparam int PRESCALE   = 60 - VEC_W;
    localparam int SETTLE_CYC = 40;
    localparam int STUCK_CYC  = 5000;
    localparam int PHASE_ITEMS = 170;

    localparam logic [31:0] PI_ACC    = 32'h8000_0000;
    localparam logic [31:0] ACC_ROUND = 32'h0000_8000;

    // Arctangent of 2^-i, one full turn being 2^32.
    localparam logic [31:0] ARCTAN_STEP [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Keeps the predicted polar results in transfer order and checks them.
    class polar_scoreboard;
        typedef struct packed {
            cp_pkg::vec_t   src;
            cp_pkg::polar_t want;
        } due_t;

        due_t due_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Rounded length and CORDIC vectoring angle of one vector.
        function cp_pkg::polar_t predict_polar(cp_pkg::vec_t v);
            longint          sx;
            longint          sy;
            longint          cx;
            longint          cy;
            longint          dx;
            longint          dy;
            longint unsigned sq;
            longint unsigned root;
            longint unsigned cand;
            logic [31:0]     acc;
            cp_pkg::polar_t  p;
            sx = longint'(v.x_component);
            sy = longint'(v.y_component);
            sq = longint'(sx * sx + sy * sy);

            // Floor square root bit by bit, then round to nearest.
            root = 0;
            for (int b = VEC_W; b >= 0; b--)
            begin
                cand = root | (longint'(1) << b);
                if (cand * cand <= sq)
                    root = cand;
            end
            if (sq - root * root > root)
                root = root + 1;

            // Vectoring rotation; the left half plane is folded over first.
            acc = '0;
            if (sx != 0 || sy != 0)
            begin
                cx = sx <<< PRESCALE;
                cy = sy <<< PRESCALE;
                if (cx < 0)
                begin
                    cx  = -cx;
                    cy  = -cy;
                    acc = PI_ACC;
                end
                for (int i = 0; i < ROT_STAGES; i++)
                begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0)
                    begin
                        cx  = cx + dx;
                        cy  = cy - dy;
                        acc = acc + ARCTAN_STEP[i];
                    end
                    else
                    begin
                        cx  = cx - dx;
                        cy  = cy + dy;
                        acc = acc - ARCTAN_STEP[i];
                    end
                end
                acc = (acc + ACC_ROUND) >> 16;
            end
            p.magnitude = root[15:0];
            p.angle     = acc[15:0];
            return p;
        endfunction

        function void note_vec(cp_pkg::vec_t v);
            due_t d;
            d.src  = v;
            d.want = predict_polar(v);
            due_q.push_back(d);
        endfunction

        function void check_result(cp_pkg::polar_t got);
            due_t d;
            if (due_q.size() == 0)
            begin
                $error("unexpected result: magnitude %0d angle %0d",
                       got.magnitude, got.angle);
                errors++;
                return;
            end
            d = due_q.pop_front();
            if (got.magnitude !== d.want.magnitude)
            begin
                $error("magnitude for (%0d,%0d): expected %0d, actual %0d",
                       d.src.x_component, d.src.y_component,
                       d.want.magnitude, got.magnitude);
                errors++;
            end
            if (got.angle !== d.want.angle)
            begin
                $error("angle for (%0d,%0d): expected %0d, actual %0d",
                       d.src.x_component, d.src.y_component,
                       d.want.angle, got.angle);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic           clk         = 1'b0;
    logic           rst_n       = 1'b0;
    logic           vec_valid   = 1'b0;
    logic           vec_stall;
    cp_pkg::vec_t   vec         = '0;
    logic           polar_valid;
    logic           polar_stall = 1'b0;
    cp_pkg::polar_t polar;

    polar_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int quiet_cyc = 0;

    cartesian_to_polar #(
        .DATA_WIDTH (VEC_W),
        .ITERATIONS (ROT_STAGES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec         (vec),
        .polar_valid (polar_valid),
        .polar_stall (polar_stall),
        .polar       (polar)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Offer one vector and hold it until the transfer happens.
    task automatic send_vec(input cp_pkg::vec_t v);
        vec_valid <= 1'b1;
        vec       <= v;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        sb.note_vec(v);
    endtask

    // Random idle cycles on the input side between transfers.
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            vec_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain();
        vec_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mix of full-range, small, and near-axis vectors.
    function automatic cp_pkg::vec_t random_vec();
        cp_pkg::vec_t v;
        int           mode;
        mode = $urandom_range(9);
        if (mode <= 5)
        begin
            v.x_component = 16'($urandom);
            v.y_component = 16'($urandom);
        end
        else if (mode <= 7)
        begin
            v.x_component = 16'(int'($urandom_range(32)) - 16);
            v.y_component = 16'(int'($urandom_range(32)) - 16);
        end
        else if (mode == 8)
        begin
            v.x_component = 16'($urandom);
            v.y_component = 16'(int'($urandom_range(8)) - 4);
        end
        else
        begin
            v.x_component = 16'(int'($urandom_range(8)) - 4);
            v.y_component = 16'($urandom);
        end
        return v;
    endfunction

    // Output side: check each transfer and choose the next stall.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && polar_valid && !polar_stall)
                sb.check_result(polar);
            if (hold_left > 0)
            begin
                polar_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                polar_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((vec_valid && !vec_stall) || (polar_valid && !polar_stall))
                quiet_cyc = 0;
            else
                quiet_cyc = quiet_cyc + 1;
            if (quiet_cyc >= STUCK_CYC)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus.
    initial
    begin
        cp_pkg::vec_t edge_vecs[$];
        int           phase_idle  [4];
        int           phase_stall [4];
        cp_pkg::vec_t v;

        phase_idle  = '{0, 87, 0, 14};
        phase_stall = '{0, 0, 87, 14};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero vector, axis extremes, corners, unit steps, and vectors
        // whose angle lands next to the half-turn or full-turn wrap.
        edge_vecs = '{
            '{16'sd0, 16'sd0},           '{16'sd32767, 16'sd0},
            '{-16'sd32768, 16'sd0},      '{16'sd0, 16'sd32767},
            '{16'sd0, -16'sd32768},      '{-16'sd32768, -16'sd32768},
            '{16'sd32767, 16'sd32767},   '{-16'sd32768, 16'sd32767},
            '{16'sd32767, -16'sd32768},  '{16'sd1, 16'sd0},
            '{-16'sd1, 16'sd0},          '{16'sd0, 16'sd1},
            '{16'sd0, -16'sd1},          '{16'sd1, 16'sd1},
            '{-16'sd1, -16'sd1},         '{16'sd1, -16'sd1},
            '{-16'sd1, 16'sd1},          '{16'sd3, 16'sd4},
            '{-16'sd32768, -16'sd1},     '{-16'sd32768, 16'sd1},
            '{16'sd32767, -16'sd1},      '{16'sd32767, 16'sd1},
            '{-16'sd5, -16'sd12}
        };
        foreach (edge_vecs[k])
            send_vec(edge_vecs[k]);
        drain();

        // Random phases under the different idle and stall patterns.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                v = random_vec();
                send_vec(v);
                idle_gap();
            end
            drain();
        end

        // Long output hold-off while the input keeps offering, so the
        // chain fills up and the input stall rises.
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 400;
        for (int n = 0; n < 80; n++)
        begin
            v = random_vec();
            send_vec(v);
        end
        drain();

        repeat (SETTLE_CYC) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cp_pkg.sv
hw/rtl/cp_front.sv
hw/rtl/cp_cell.sv
hw/rtl/cp_back.sv
hw/rtl/cartesian_to_polar.sv
dv/tb_cartesian_to_polar.sv
